// ===== design/stok_pkg.sv =====
// ----------------------------------------------------------------------------
// stok_pkg
// Types, character codes and keyword tables shared by the tokenizer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package stok_pkg;

  localparam int unsigned OFFSET_W = 24;
  localparam int unsigned LENGTH_W = 16;
  localparam int unsigned LINE_W   = 24;

  typedef enum logic [3:0] {
    TK_END      = 4'd0,
    TK_NAME     = 4'd1,
    TK_FUNCTION = 4'd2,
    TK_RETURN   = 4'd3,
    TK_LPAREN   = 4'd4,
    TK_RPAREN   = 4'd5,
    TK_LBRACE   = 4'd6,
    TK_RBRACE   = 4'd7,
    TK_COMMA    = 4'd8,
    TK_ARROW    = 4'd9
  } token_kind_e;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_NAME  = 3'd1,
    MODE_SLASH = 3'd2,
    MODE_LINE  = 3'd3,
    MODE_BLOCK = 3'd4,
    MODE_STAR  = 3'd5,
    MODE_EQ    = 3'd6
  } scan_mode_e;

  typedef struct packed {
    token_kind_e         kind;
    logic [OFFSET_W-1:0] offset;
    logic [LENGTH_W-1:0] length;
    logic [LINE_W-1:0]   line;
    logic                last;
  } token_t;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  localparam int unsigned KW_FUNC_LEN = 8;
  localparam int unsigned KW_RET_LEN  = 6;

  function automatic logic [7:0] kw_func_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h66; // f
      3'd1:    ch = 8'h75; // u
      3'd2:    ch = 8'h6E; // n
      3'd3:    ch = 8'h63; // c
      3'd4:    ch = 8'h74; // t
      3'd5:    ch = 8'h69; // i
      3'd6:    ch = 8'h6F; // o
      default: ch = 8'h6E; // n
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] kw_ret_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h72; // r
      3'd1:    ch = 8'h65; // e
      3'd2:    ch = 8'h74; // t
      3'd3:    ch = 8'h75; // u
      3'd4:    ch = 8'h72; // r
      3'd5:    ch = 8'h6E; // n
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic is_name_start(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           (c == CH_UNDER) || (c == CH_MINUS);
  endfunction

  function automatic logic is_name_part(input logic [7:0] c);
    return is_name_start(c) || ((c >= 8'h30) && (c <= 8'h39)) || (c == CH_DOT);
  endfunction

endpackage

`default_nettype wire

// ===== design/stok_scan.sv =====
// ----------------------------------------------------------------------------
// stok_scan
// Scanner state and token decode: consumes one byte per transfer and yields
// up to two tokens for it.
// ----------------------------------------------------------------------------
`default_nettype none

module stok_scan import stok_pkg::*; #(
  parameter int unsigned POSITION_BITS = 24,
  parameter int unsigned LENGTH_BITS   = 16,
  parameter int unsigned LINE_BITS     = 24
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] char_code_i,
  input  wire logic       end_of_text_i,
  output token_t          tok0_o,
  output token_t          tok1_o,
  output logic [1:0]      tok_cnt_o
);

  scan_mode_e mode_q, mode_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d, start_q, start_d;
  logic [LENGTH_BITS-1:0]   len_q, len_d;
  logic [LINE_BITS-1:0]     line_q, line_d;
  logic [1:0]               hits_q, hits_d;

  logic       run_idle;
  logic [1:0] hit_now, hit_first;
  logic       pend_v, idle_v;
  token_t     pend_tok, idle_tok;
  logic [LINE_BITS-1:0]     line_inc;
  logic [LENGTH_BITS-1:0]   len_inc;
  logic [POSITION_BITS-1:0] pos_inc;

  assign line_inc = (line_q == '1) ? line_q : line_q + 1'b1;
  assign len_inc  = (len_q == '1) ? len_q : len_q + 1'b1;
  assign pos_inc  = (pos_q == '1) ? pos_q : pos_q + 1'b1;

  // Keyword tracking against the byte at the current name index.
  assign hit_now[0] = (len_q < LENGTH_BITS'(KW_FUNC_LEN)) &&
                      (char_code_i == kw_func_char(len_q[2:0]));
  assign hit_now[1] = (len_q < LENGTH_BITS'(KW_RET_LEN)) &&
                      (char_code_i == kw_ret_char(len_q[2:0]));
  assign hit_first  = {char_code_i == kw_ret_char(3'd0),
                       char_code_i == kw_func_char(3'd0)};

  // The byte is scanned from idle either directly or after a held token ends.
  always_comb begin
    run_idle = 1'b0;
    if (accept_i && !end_of_text_i) begin
      unique case (mode_q)
        MODE_NAME:  run_idle = !is_name_part(char_code_i);
        MODE_SLASH: run_idle = (char_code_i != CH_SLASH) && (char_code_i != CH_STAR);
        MODE_EQ:    run_idle = (char_code_i != CH_GT);
        MODE_LINE, MODE_BLOCK, MODE_STAR: run_idle = 1'b0;
        default:    run_idle = 1'b1;
      endcase
    end
  end

  // Next state.
  always_comb begin
    mode_d  = mode_q;
    pos_d   = pos_q;
    start_d = start_q;
    len_d   = len_q;
    line_d  = line_q;
    hits_d  = hits_q;
    if (accept_i) begin
      if (end_of_text_i) begin
        mode_d  = MODE_IDLE;
        pos_d   = '0;
        start_d = '0;
        len_d   = '0;
        line_d  = LINE_BITS'(1);
        hits_d  = 2'b11;
      end else begin
        pos_d = pos_inc;
        unique case (mode_q)
          MODE_NAME: begin
            if (!run_idle) begin
              hits_d = hits_q & hit_now;
              len_d  = len_inc;
            end
          end
          MODE_SLASH: begin
            if (char_code_i == CH_SLASH) begin
              mode_d = MODE_LINE;
            end else if (char_code_i == CH_STAR) begin
              mode_d = MODE_BLOCK;
            end
          end
          MODE_EQ: begin
            mode_d = MODE_IDLE;
          end
          MODE_LINE: begin
            if (char_code_i == CH_LF) begin
              line_d = line_inc;
              mode_d = MODE_IDLE;
            end
          end
          MODE_BLOCK, MODE_STAR: begin
            if (char_code_i == CH_SLASH && mode_q == MODE_STAR) begin
              mode_d = MODE_IDLE;
            end else if (char_code_i == CH_STAR) begin
              mode_d = MODE_STAR;
            end else begin
              if (char_code_i == CH_LF) begin
                line_d = line_inc;
              end
              mode_d = MODE_BLOCK;
            end
          end
          default: ;
        endcase
        if (run_idle) begin
          mode_d = MODE_IDLE;
          if (char_code_i == CH_LF) begin
            line_d = line_inc;
          end else if (char_code_i == CH_SLASH) begin
            mode_d  = MODE_SLASH;
            start_d = pos_q;
          end else if (char_code_i == CH_EQUALS) begin
            mode_d  = MODE_EQ;
            start_d = pos_q;
          end else if (is_name_start(char_code_i)) begin
            mode_d  = MODE_NAME;
            start_d = pos_q;
            len_d   = LENGTH_BITS'(1);
            hits_d  = hit_first;
          end
        end
      end
    end
  end

  // Token outputs. Every token of one transfer carries the current line.
  always_comb begin
    pend_v            = 1'b0;
    pend_tok.kind     = TK_END;
    pend_tok.offset   = OFFSET_W'(start_q);
    pend_tok.length   = LENGTH_W'(1);
    pend_tok.line     = LINE_W'(line_q);
    pend_tok.last     = 1'b0;
    idle_v            = 1'b0;
    idle_tok.kind     = TK_END;
    idle_tok.offset   = OFFSET_W'(pos_q);
    idle_tok.length   = LENGTH_W'(1);
    idle_tok.line     = LINE_W'(line_q);
    idle_tok.last     = 1'b1;

    if (accept_i) begin
      // A held name, slash or equals closes when this byte does not extend it.
      if (mode_q == MODE_NAME && (end_of_text_i || run_idle)) begin
        pend_v          = 1'b1;
        pend_tok.length = LENGTH_W'(len_q);
        if (hits_q[0] && len_q == LENGTH_BITS'(KW_FUNC_LEN)) begin
          pend_tok.kind = TK_FUNCTION;
        end else if (hits_q[1] && len_q == LENGTH_BITS'(KW_RET_LEN)) begin
          pend_tok.kind = TK_RETURN;
        end else begin
          pend_tok.kind = TK_NAME;
        end
      end else if ((mode_q == MODE_SLASH || mode_q == MODE_EQ) &&
                   (end_of_text_i || run_idle)) begin
        pend_v = 1'b1;
      end else if (mode_q == MODE_EQ && !end_of_text_i) begin
        pend_v          = 1'b1;
        pend_tok.kind   = TK_ARROW;
        pend_tok.length = LENGTH_W'(2);
      end

      if (end_of_text_i) begin
        idle_v          = 1'b1;
        idle_tok.length = '0;
      end else if (run_idle) begin
        idle_v = 1'b1;
        unique case (char_code_i)
          CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_SLASH, CH_EQUALS: idle_v = 1'b0;
          CH_LPAREN: idle_tok.kind = TK_LPAREN;
          CH_RPAREN: idle_tok.kind = TK_RPAREN;
          CH_LBRACE: idle_tok.kind = TK_LBRACE;
          CH_RBRACE: idle_tok.kind = TK_RBRACE;
          CH_COMMA:  idle_tok.kind = TK_COMMA;
          default:   idle_v = !is_name_start(char_code_i);
        endcase
      end
    end
  end

  // Pack the tokens so that the first one present always leads.
  always_comb begin
    tok1_o        = idle_tok;
    tok0_o        = pend_v ? pend_tok : idle_tok;
    tok0_o.last   = !(pend_v && idle_v);
    tok_cnt_o     = {1'b0, pend_v} + {1'b0, idle_v};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      pos_q   <= '0;
      start_q <= '0;
      len_q   <= '0;
      line_q  <= LINE_BITS'(1);
      hits_q  <= 2'b11;
    end else begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      len_q   <= len_d;
      line_q  <= line_d;
      hits_q  <= hits_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/stok_queue.sv =====
// ----------------------------------------------------------------------------
// stok_queue
// Four-entry token queue: takes up to two tokens per cycle, gives one.
// ----------------------------------------------------------------------------
`default_nettype none

module stok_queue import stok_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire token_t     tok0_i,
  input  wire token_t     tok1_i,
  input  wire logic [1:0] push_cnt_i,
  output logic            room_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output token_t          head_o
);

  token_t     entry_q [4];
  logic [1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [2:0] count_q, count_d;
  logic       pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != 3'd0);
  assign head_o      = entry_q[rd_ptr_q];
  // Room for the worst case of two tokens from one transfer.
  assign room_o      = (count_q <= 3'd2);

  assign wr_ptr_d = wr_ptr_q + push_cnt_i;
  assign rd_ptr_d = rd_ptr_q + {1'b0, pop};
  assign count_d  = count_q + {1'b0, push_cnt_i} - {2'b00, pop};

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      entry_q[wr_ptr_q] <= tok0_i;
    end
    if (push_cnt_i == 2'd2) begin
      entry_q[wr_ptr_q + 2'd1] <= tok1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/source_tokenizer.sv =====
// ----------------------------------------------------------------------------
// source_tokenizer
// Streaming lexical scanner: one source byte per transfer in, tokens out.
// ----------------------------------------------------------------------------
// Tokens are registered in the output queue and presented from its head.
// Throughput: one byte per cycle; the input stalls only while fewer than two
// of the four output queue slots are free.
// Reset: asynchronous; scanner idle, offset 0, line 1, output queue empty.
`default_nettype none

module source_tokenizer import stok_pkg::*; #(
  parameter int unsigned POSITION_BITS = 24,
  parameter int unsigned LENGTH_BITS   = 16,
  parameter int unsigned LINE_BITS     = 24
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [7:0]          char_code_i,
  input  wire logic                end_of_text_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [3:0]               token_kind_o,
  output logic [OFFSET_W-1:0]      token_offset_o,
  output logic [LENGTH_W-1:0]      token_length_o,
  output logic [LINE_W-1:0]        token_line_o,
  output logic                     last_of_item_o
);

  token_t     tok0, tok1, head;
  logic [1:0] tok_cnt;
  logic       room;

  assign in_ready_o = room;

  stok_scan #(
    .POSITION_BITS(POSITION_BITS),
    .LENGTH_BITS  (LENGTH_BITS),
    .LINE_BITS    (LINE_BITS)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_valid_i && room),
    .char_code_i  (char_code_i),
    .end_of_text_i(end_of_text_i),
    .tok0_o       (tok0),
    .tok1_o       (tok1),
    .tok_cnt_o    (tok_cnt)
  );

  stok_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tok0_i     (tok0),
    .tok1_i     (tok1),
    .push_cnt_i (tok_cnt),
    .room_o     (room),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .head_o     (head)
  );

  assign token_kind_o   = head.kind;
  assign token_offset_o = head.offset;
  assign token_length_o = head.length;
  assign token_line_o   = head.line;
  assign last_of_item_o = head.last;

endmodule

`default_nettype wire

// ===== dv/tb_source_tokenizer.sv =====
// ----------------------------------------------------------------------------
// tb_source_tokenizer
// Streams source text into the tokenizer and checks every token it returns
// against a cycle-free scanner model kept inside the bench. A short table of
// hand-picked bytes comes first, then randomized text built from names,
// keywords, punctuation, blanks, comments and noise, with bursty input and a
// stalling token consumer.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_source_tokenizer;
  import stok_pkg::*;

  localparam int unsigned TARGET_ITEMS = 1550;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned STUCK_LIMIT  = 4000;

  localparam logic [63:0] WORD_FUNCTION = "function";
  localparam logic [47:0] WORD_RETURN   = "return";

  localparam logic [7:0] PUNCT  [5] = '{CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_COMMA};
  localparam logic [7:0] BLANKS [4] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};

  typedef struct {
    logic [7:0]  ch;
    logic        eot;
    logic        typed;
    token_kind_e kind;
    int unsigned off;
    int unsigned len;
    int unsigned line;
  } stim_row_t;

  // Single-token rows carry their answer; the rest go through the scanner model.
  stim_row_t directed_rows [28] = '{
    '{CH_LPAREN, 1'b0, 1'b1, TK_LPAREN, 0, 1, 1},
    '{CH_RPAREN, 1'b0, 1'b1, TK_RPAREN, 1, 1, 1},
    '{CH_LBRACE, 1'b0, 1'b1, TK_LBRACE, 2, 1, 1},
    '{CH_RBRACE, 1'b0, 1'b1, TK_RBRACE, 3, 1, 1},
    '{CH_COMMA,  1'b0, 1'b1, TK_COMMA,  4, 1, 1},
    '{8'h00,     1'b0, 1'b1, TK_END,    5, 1, 1},
    '{8'hFF,     1'b0, 1'b1, TK_END,    6, 1, 1},
    '{CH_EQUALS, 1'b0, 1'b0, TK_END,    0, 0, 0},
    '{CH_GT,     1'b0, 1'b1, TK_ARROW,  7, 2, 1},
    '{CH_SLASH,  1'b0, 1'b0, TK_END,    0, 0, 0},
    '{CH_LF,     1'b0, 1'b1, TK_END,    9, 1, 1},
    '{"r",       1'b0, 1'b0, TK_END,    0, 0, 0},
    '{"e",       1'b0, 1'b0, TK_END,    0, 0, 0},
    '{"t",       1'b0, 1'b0, TK_END,    0, 0, 0},
    '{"u",       1'b0, 1'b0, TK_END,    0, 0, 0},
    '{"r",       1'b0, 1'b0, TK_END,    0, 0, 0},
    '{"n",       1'b0, 1'b0, TK_END,    0, 0, 0},
    '{CH_EQUALS, 1'b0, 1'b1, TK_RETURN, 11, 6, 2},
    '{8'hFF,     1'b1, 1'b0, TK_END,    0, 0, 0},
    '{"f",       1'b0, 1'b0, TK_END,    0, 0, 0},
    '{"u",       1'b0, 1'b0, TK_END,    0, 0, 0},
    '{"n",       1'b0, 1'b0, TK_END,    0, 0, 0},
    '{"c",       1'b0, 1'b0, TK_END,    0, 0, 0},
    '{"t",       1'b0, 1'b0, TK_END,    0, 0, 0},
    '{"i",       1'b0, 1'b0, TK_END,    0, 0, 0},
    '{"o",       1'b0, 1'b0, TK_END,    0, 0, 0},
    '{"n",       1'b0, 1'b0, TK_END,    0, 0, 0},
    '{8'h00,     1'b1, 1'b0, TK_END,    0, 0, 0}
  };

  string word_pool [6] = '{"function", "return", "functions", "retur", "func", "returned"};

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [7:0]          char_code_i;
  logic                end_of_text_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [3:0]          token_kind_o;
  logic [OFFSET_W-1:0] token_offset_o;
  logic [LENGTH_W-1:0] token_length_o;
  logic [LINE_W-1:0]   token_line_o;
  logic                last_of_item_o;

  // Scanner model state.
  scan_mode_e          scan_state;
  logic [OFFSET_W-1:0] next_offset;
  logic [OFFSET_W-1:0] token_start;
  logic [LENGTH_W-1:0] name_len;
  logic [LINE_W-1:0]   line_no;
  logic [1:0]          kw_alive;

  token_t step_tokens[$];
  token_t expected_tokens[$];
  token_t got_token;
  token_t want_token;

  int unsigned mismatches    = 0;
  int unsigned counted_items = 0;
  int unsigned burst_left    = 0;
  int unsigned steady_left   = 0;
  int unsigned text_len      = 0;
  int unsigned stuck_cycles  = 0;
  logic        hold_req      = 1'b0;

  source_tokenizer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .char_code_i    (char_code_i),
    .end_of_text_i  (end_of_text_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .token_kind_o   (token_kind_o),
    .token_offset_o (token_offset_o),
    .token_length_o (token_length_o),
    .token_line_o   (token_line_o),
    .last_of_item_o (last_of_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Scanner model
  // ---------------------------------------------------------------------------
  function automatic logic is_lead(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER || c == CH_MINUS;
  endfunction

  function automatic logic is_body(input logic [7:0] c);
    return is_lead(c) || (c >= "0" && c <= "9") || c == CH_DOT;
  endfunction

  function automatic void restart_scan();
    scan_state  = MODE_IDLE;
    next_offset = '0;
    token_start = '0;
    name_len    = '0;
    line_no     = LINE_W'(1);
    kw_alive    = 2'b11;
  endfunction

  function automatic void push_token(input token_kind_e k, input logic [OFFSET_W-1:0] off,
                                     input logic [LENGTH_W-1:0] len);
    token_t t;
    t.kind   = k;
    t.offset = off;
    t.length = len;
    t.line   = line_no;
    t.last   = 1'b0;
    step_tokens.push_back(t);
  endfunction

  function automatic void bump_line();
    if (line_no != '1) line_no++;
  endfunction

  // Drops a keyword candidate as soon as the name leaves its spelling.
  function automatic void track_keyword(input logic [7:0] c);
    int i = int'(name_len);
    if (i >= KW_FUNC_LEN || WORD_FUNCTION[63-8*i -: 8] != c) kw_alive[0] = 1'b0;
    if (i >= KW_RET_LEN || WORD_RETURN[47-8*i -: 8] != c) kw_alive[1] = 1'b0;
  endfunction

  function automatic void name_token();
    token_kind_e k;
    k = TK_NAME;
    if (kw_alive[0] && name_len == KW_FUNC_LEN) k = TK_FUNCTION;
    else if (kw_alive[1] && name_len == KW_RET_LEN) k = TK_RETURN;
    push_token(k, token_start, name_len);
  endfunction

  function automatic void scan_fresh(input logic [7:0] c, input logic [OFFSET_W-1:0] p);
    case (c)
      CH_SPACE, CH_TAB, CH_CR: ;
      CH_LF: bump_line();
      CH_SLASH: begin
        scan_state  = MODE_SLASH;
        token_start = p;
      end
      CH_EQUALS: begin
        scan_state  = MODE_EQ;
        token_start = p;
      end
      CH_LPAREN: push_token(TK_LPAREN, p, LENGTH_W'(1));
      CH_RPAREN: push_token(TK_RPAREN, p, LENGTH_W'(1));
      CH_LBRACE: push_token(TK_LBRACE, p, LENGTH_W'(1));
      CH_RBRACE: push_token(TK_RBRACE, p, LENGTH_W'(1));
      CH_COMMA:  push_token(TK_COMMA, p, LENGTH_W'(1));
      default: begin
        if (is_lead(c)) begin
          scan_state  = MODE_NAME;
          token_start = p;
          name_len    = '0;
          kw_alive    = 2'b11;
          track_keyword(c);
          name_len    = LENGTH_W'(1);
        end else begin
          push_token(TK_END, p, LENGTH_W'(1));
        end
      end
    endcase
  endfunction

  // Advances the model by one transfer.
  function automatic void predict_item(input logic [7:0] c, input logic eot);
    logic [OFFSET_W-1:0] p = next_offset;
    token_t              t;
    step_tokens.delete();
    if (eot) begin
      if (scan_state == MODE_NAME) name_token();
      else if (scan_state == MODE_SLASH || scan_state == MODE_EQ)
        push_token(TK_END, token_start, LENGTH_W'(1));
      push_token(TK_END, next_offset, LENGTH_W'(0));
      restart_scan();
    end else begin
      case (scan_state)
        MODE_NAME: begin
          if (is_body(c)) begin
            track_keyword(c);
            if (name_len != '1) name_len++;
          end else begin
            name_token();
            scan_state = MODE_IDLE;
            scan_fresh(c, p);
          end
        end
        MODE_SLASH: begin
          if (c == CH_SLASH) scan_state = MODE_LINE;
          else if (c == CH_STAR) scan_state = MODE_BLOCK;
          else begin
            push_token(TK_END, token_start, LENGTH_W'(1));
            scan_state = MODE_IDLE;
            scan_fresh(c, p);
          end
        end
        MODE_EQ: begin
          if (c == CH_GT) begin
            push_token(TK_ARROW, token_start, LENGTH_W'(2));
            scan_state = MODE_IDLE;
          end else begin
            push_token(TK_END, token_start, LENGTH_W'(1));
            scan_state = MODE_IDLE;
            scan_fresh(c, p);
          end
        end
        MODE_LINE: begin
          if (c == CH_LF) begin
            bump_line();
            scan_state = MODE_IDLE;
          end
        end
        MODE_BLOCK, MODE_STAR: begin
          if (c == CH_SLASH && scan_state == MODE_STAR) scan_state = MODE_IDLE;
          else if (c == CH_STAR) scan_state = MODE_STAR;
          else begin
            if (c == CH_LF) bump_line();
            scan_state = MODE_BLOCK;
          end
        end
        default: begin
          scan_state = MODE_IDLE;
          scan_fresh(c, p);
        end
      endcase
      if (next_offset != '1) next_offset++;
    end
    if (step_tokens.size() > 0) begin
      t = step_tokens.pop_back();
      t.last = 1'b1;
      step_tokens.push_back(t);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Byte sender: bursts of random length with random gaps in between.
  // Called and returning at a falling edge.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [7:0] c, input logic eot,
                           input logic use_typed = 1'b0, input token_t typed_tok = '0);
    int gap;
    if (burst_left == 0) begin
      gap = (steady_left > 0 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 48);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    in_valid_i    <= 1'b1;
    char_code_i   <= c;
    end_of_text_i <= eot;
    do @(posedge clk_i); while (!in_ready_o);
    predict_item(c, eot);
    if (use_typed) expected_tokens.push_back(typed_tok);
    else foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
    counted_items++;
    burst_left--;
    if (steady_left > 0) steady_left--;
    text_len = eot ? 0 : text_len + 1;
    @(negedge clk_i);
  endtask

  task automatic drain_tokens();
    in_valid_i <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] lead_char();
    case ($urandom_range(0, 5))
      0, 1:    return 8'h61 + 8'($urandom_range(0, 25));
      2, 3:    return 8'h41 + 8'($urandom_range(0, 25));
      4:       return CH_UNDER;
      default: return CH_MINUS;
    endcase
  endfunction

  function automatic logic [7:0] body_char();
    case ($urandom_range(0, 5))
      0:       return 8'h30 + 8'($urandom_range(0, 9));
      1:       return CH_DOT;
      default: return lead_char();
    endcase
  endfunction

  // Mostly well-formed text, with stray bytes, unfinished comments and lone
  // operators mixed in. Texts are kept short so the end-of-text path is busy.
  task automatic send_fragment();
    int         sel = $urandom_range(0, 99);
    int         n;
    logic [7:0] c;
    string      w;
    if (text_len > 150) sel = 99;
    if (sel < 20) begin
      send_item(lead_char(), 1'b0);
      n = $urandom_range(0, 9);
      repeat (n) send_item(body_char(), 1'b0);
    end else if (sel < 28) begin
      w = word_pool[$urandom_range(0, 5)];
      for (int i = 0; i < w.len(); i++) send_item(w[i], 1'b0);
    end else if (sel < 45) begin
      n = $urandom_range(0, 5);
      if (n < 5) send_item(PUNCT[n], 1'b0);
      else begin
        send_item(CH_EQUALS, 1'b0);
        send_item(CH_GT, 1'b0);
      end
    end else if (sel < 58) begin
      n = $urandom_range(1, 4);
      repeat (n) send_item(BLANKS[$urandom_range(0, 3)], 1'b0);
    end else if (sel < 66) begin
      send_item(CH_SLASH, 1'b0);
      send_item(CH_SLASH, 1'b0);
      n = $urandom_range(0, 15);
      repeat (n) begin
        c = 8'($urandom_range(0, 255));
        send_item((c == CH_LF) ? CH_SPACE : c, 1'b0);
      end
      if ($urandom_range(0, 7) != 0) send_item(CH_LF, 1'b0);
    end else if (sel < 74) begin
      send_item(CH_SLASH, 1'b0);
      send_item(CH_STAR, 1'b0);
      n = $urandom_range(0, 15);
      repeat (n) begin
        case ($urandom_range(0, 3))
          0:       c = CH_STAR;
          1:       c = CH_LF;
          2:       c = CH_SLASH;
          default: c = 8'($urandom_range(0, 255));
        endcase
        send_item(c, 1'b0);
      end
      if ($urandom_range(0, 7) != 0) begin
        send_item(CH_STAR, 1'b0);
        send_item(CH_SLASH, 1'b0);
      end
    end else if (sel < 82) begin
      send_item($urandom_range(0, 1) ? CH_SLASH : CH_EQUALS, 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b0);
    end else if (sel < 96) begin
      n = $urandom_range(1, 3);
      repeat (n) send_item(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      send_item(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    token_t row_tok;
    in_valid_i    = 1'b0;
    char_code_i   = 8'h00;
    end_of_text_i = 1'b0;
    rst_ni        = 1'b0;
    restart_scan();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[r]) begin
      row_tok.kind   = directed_rows[r].kind;
      row_tok.offset = OFFSET_W'(directed_rows[r].off);
      row_tok.length = LENGTH_W'(directed_rows[r].len);
      row_tok.line   = LINE_W'(directed_rows[r].line);
      row_tok.last   = 1'b1;
      send_item(directed_rows[r].ch, directed_rows[r].eot, directed_rows[r].typed, row_tok);
    end

    counted_items = 0;
    while (counted_items < TARGET_ITEMS) begin
      // Keep offering bytes without gaps while the consumer holds off.
      if (counted_items >= TARGET_ITEMS / 3 && hold_req == 1'b0 && steady_left == 0 &&
          counted_items < TARGET_ITEMS / 3 + 20) begin
        hold_req    = 1'b1;
        steady_left = 300;
      end
      send_fragment();
    end

    // Let every token come back before the text is closed.
    drain_tokens();
    send_item(8'($urandom_range(0, 255)), 1'b1);

    drain_tokens();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Token consumer: stall density changes from phase to phase, and one long
  // hold-off fills the block so that it has to stall its input.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned hold_left;
    int unsigned phase_left;
    int unsigned stall_pct;
    logic        hold_done;
    hold_left   = 0;
    phase_left  = 0;
    stall_pct   = 0;
    hold_done   = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done && steady_left > 0) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (phase_left == 0) begin
          case ($urandom_range(0, 3))
            0:       stall_pct = 0;
            1:       stall_pct = 20;
            2:       stall_pct = 50;
            default: stall_pct = 85;
          endcase
          phase_left = $urandom_range(20, 200);
        end
        phase_left--;
        out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_miss(input string what, input token_t want, input token_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: expected kind %0d offset %0d length %0d line %0d last %0b",
               what, want.kind, want.offset, want.length, want.line, want.last);
      $display("  got kind %0d offset %0d length %0d line %0d last %0b",
               got.kind, got.offset, got.length, got.line, got.last);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_token.kind   = token_kind_e'(token_kind_o);
      got_token.offset = token_offset_o;
      got_token.length = token_length_o;
      got_token.line   = token_line_o;
      got_token.last   = last_of_item_o;
      if (expected_tokens.size() == 0) begin
        report_miss("token with nothing pending", '0, got_token);
      end else begin
        want_token = expected_tokens.pop_front();
        if (got_token !== want_token) report_miss("token mismatch", want_token, got_token);
      end
    end
  end

  // Ends the run when no transfer happens on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles == STUCK_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

endmodule
